[design/touch_stroke_capture_assert.svh]
// Assertion macros for the touch stroke capture block.
`ifndef TOUCH_STROKE_CAPTURE_ASSERT_SVH
`define TOUCH_STROKE_CAPTURE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge, quiet while reset is low.
`define TSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[design/tsc_pkg.sv]
// Shared types, codes and constants of the touch stroke capture block.
`default_nettype none

package tsc_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam logic [15:0] GAP_RESET = 16'd200;

    // Action codes of an input beat
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_SAVED   = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_NOTOUCH = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_READOK  = 3'd4;
    localparam logic [2:0] ST_READOOR = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    // Register index of the configuration port
    localparam logic REG_STROKE_GAP = 1'b0;

    typedef struct packed {
        logic [1:0]  action;
        logic        touch_detected;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [31:0] tick_now;
        logic [9:0]  read_index;
    } t_cmd_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] point_count;
        logic        joins_previous;
        logic [11:0] read_x;
        logic [11:0] read_y;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
        logic done;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[design/tsc_ctrl.sv]
// Controller state machine: sequences load, execute and result beat.
`default_nettype none
`include "touch_stroke_capture_assert.svh"

module tsc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output tsc_pkg::t_dp_cmd     o_cmd,
    output logic                 o_busy
);

    tsc_pkg::t_state r_state;
    tsc_pkg::t_state n_state;
    logic            accept;

    assign accept = i_start && (r_state == tsc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = tsc_pkg::S_EXEC;
                end
            end
            tsc_pkg::S_EXEC: n_state = tsc_pkg::S_DONE;
            tsc_pkg::S_DONE: n_state = tsc_pkg::S_IDLE;
            default:         n_state = tsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_cmd.done = 1'b0;
        o_busy     = 1'b1;
        case (r_state)
            tsc_pkg::S_IDLE: begin
                o_cmd.load = i_start;
                o_busy     = 1'b0;
            end
            tsc_pkg::S_EXEC: o_cmd.exec = 1'b1;
            tsc_pkg::S_DONE: o_cmd.done = 1'b1;
            default:         o_busy     = 1'b1;
        endcase
    end

    `TSC_ASSERT(a_accept_to_result, i_clk, i_rst_n, accept |-> ##2 o_cmd.done, "result beat missing two cycles after accept")
    `TSC_ASSERT(a_done_frees, i_clk, i_rst_n, o_cmd.done |=> !o_busy, "block still busy after result beat")
    `TSC_ASSERT_ALWAYS(a_cmd_onehot, i_clk, $onehot0(o_cmd), "datapath commands overlap")

endmodule

`default_nettype wire

[design/tsc_datapath.sv]
// Datapath: item latch, stroke state, point store and result registers.
`default_nettype none
`include "touch_stroke_capture_assert.svh"

module tsc_datapath #(
    parameter int STORE_DEPTH = tsc_pkg::STORE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tsc_pkg::t_dp_cmd i_cmd,
    input  wire tsc_pkg::t_cmd_in i_item,
    input  wire logic [15:0]      i_gap,
    output tsc_pkg::t_result      o_result
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int CMPW = (CW > 10) ? CW : 10;
    localparam int OW   = (CW > 11) ? CW : 11;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    logic [23:0]          mem [STORE_DEPTH];

    tsc_pkg::t_cmd_in     r_item;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        r_mark;
    logic [CW-1:0]        n_mark;
    logic [31:0]          r_last_time;
    logic [31:0]          n_last_time;
    logic [23:0]          r_last_xy;
    logic [23:0]          n_last_xy;
    logic [2:0]           r_status;
    logic [2:0]           n_status;
    logic                 r_rd_ok;
    logic                 n_rd_ok;
    logic [23:0]          r_mem_q;

    logic                 full;
    logic                 wr_en;
    logic [23:0]          item_xy;
    logic [31:0]          gap_now;
    logic [CMPW-1:0]      ridx_ext;
    logic [CMPW-1:0]      cnt_cmp;
    logic [OW-1:0]        cnt_out;

    assign full     = (r_count == DEPTH_C);
    assign item_xy  = {r_item.coord_x, r_item.coord_y};
    assign gap_now  = r_item.tick_now - r_last_time;
    assign ridx_ext = CMPW'(r_item.read_index);
    assign cnt_cmp  = CMPW'(r_count);
    assign cnt_out  = OW'(r_count);

    // Latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_mark      = r_mark;
        n_last_time = r_last_time;
        n_last_xy   = r_last_xy;
        n_status    = tsc_pkg::ST_NOTOUCH;
        n_rd_ok     = 1'b0;
        wr_en       = 1'b0;
        case (r_item.action)
            tsc_pkg::ACT_SAMPLE: begin
                if (full) begin
                    n_status = tsc_pkg::ST_FULL;
                end else if (!r_item.touch_detected) begin
                    if (gap_now > {16'd0, i_gap}) begin
                        n_mark = r_count;
                    end
                end else begin
                    n_last_time = r_item.tick_now;
                    if ((r_count != '0) && (item_xy == r_last_xy)) begin
                        n_status = tsc_pkg::ST_DUP;
                    end else begin
                        wr_en     = 1'b1;
                        n_count   = r_count + CW'(1);
                        n_last_xy = item_xy;
                        n_status  = tsc_pkg::ST_SAVED;
                    end
                end
            end
            tsc_pkg::ACT_READ: begin
                n_rd_ok  = (ridx_ext < cnt_cmp);
                n_status = n_rd_ok ? tsc_pkg::ST_READOK : tsc_pkg::ST_READOOR;
            end
            tsc_pkg::ACT_CLEAR: begin
                n_count     = '0;
                n_mark      = '0;
                n_last_time = '0;
                n_last_xy   = '0;
                n_status    = tsc_pkg::ST_CLEARED;
            end
            default: n_status = tsc_pkg::ST_NOTOUCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mark      <= '0;
            r_last_time <= '0;
            r_last_xy   <= '0;
        end else if (i_cmd.exec) begin
            r_count     <= n_count;
            r_mark      <= n_mark;
            r_last_time <= n_last_time;
            r_last_xy   <= n_last_xy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // Point store: at most one write and one registered read per execute cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[r_count[AW-1:0]] <= item_xy;
        end
        if (i_cmd.exec) begin
            r_mem_q <= mem[ridx_ext[AW-1:0]];
        end
    end

    assign o_result.status         = r_status;
    assign o_result.point_count    = cnt_out[10:0];
    assign o_result.joins_previous = (r_count >= CW'(2)) && ((r_count - CW'(1)) != r_mark);
    assign o_result.read_x         = r_rd_ok ? r_mem_q[23:12] : 12'd0;
    assign o_result.read_y         = r_rd_ok ? r_mem_q[11:0] : 12'd0;

    `TSC_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= DEPTH_C) && (r_mark <= r_count), "count or stroke mark out of range")
    `TSC_ASSERT(a_count_hold, i_clk, i_rst_n, !i_cmd.exec |=> $stable(r_count), "count moved outside execute")
    `TSC_ASSERT(a_full_status, i_clk, i_rst_n, ($past(i_cmd.exec) && (r_status == tsc_pkg::ST_FULL)) |-> full, "full status with room left")

endmodule

`default_nettype wire

[design/touch_stroke_capture.sv]
// Top level of the touch stroke capture block: register port, controller, datapath.
// An accepted item walks the controller through execute (store access) and then result;
// its result beat is marked on o_done in the result state. The controller takes no new
// item until the last is through: it holds busy through the execute and result states.
// Reset (i_rst_n low, synchronous): store empty, stroke state and last point cleared,
// stroke gap back to 200 ticks; store contents stay undefined. Results cannot be stalled.
`default_nettype none

module touch_stroke_capture #(
    parameter int STORE_DEPTH = tsc_pkg::STORE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // command channel
    input  wire logic             start,
    output logic                  busy,
    input  wire tsc_pkg::t_cmd_in i_cmd,
    // result channel: one beat per item, marked by o_done
    output logic                  o_done,
    output tsc_pkg::t_result      o_result,
    // configuration port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    tsc_pkg::t_dp_cmd dp_cmd;
    logic [15:0]      r_gap;
    logic             reg_hit;

    // Register map: stroke gap at byte address 0; anything at address 4 reads zero.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == tsc_pkg::REG_STROKE_GAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= tsc_pkg::GAP_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_gap <= pwdata[15:0];
        end
    end

    // Read data from the address alone; the stroke gap sits in the low half.
    assign prdata = reg_hit ? {16'd0, r_gap} : 32'd0;

    // Sequence each accepted beat through load, execute and result.
    tsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // Hold stroke state and the point store; drive the result fields.
    tsc_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_cmd),
        .i_gap    (r_gap),
        .o_result (o_result)
    );

    // Strobe the result beat for exactly one cycle.
    assign o_done = dp_cmd.done;

endmodule

`default_nettype wire
